>>> hw/rtl/rgbhsl_pkg.sv
// Shared constants and payload types for the RGB to HSL converter.
package rgbhsl_pkg;

  localparam int CHANNEL_BITS  = 8;
  localparam int FRACTION_BITS = 16;
  localparam int CHAN_MAX      = (1 << CHANNEL_BITS) - 1;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [FRACTION_BITS-1:0] hue;
    logic [FRACTION_BITS-1:0] saturation;
    logic [FRACTION_BITS-1:0] lightness;
  } hsl_t;

endpackage

>>> hw/rtl/rgb_to_hsl.sv
// RGB to HSL converter, fully pipelined, top level.
//
// Input channel pixel/pixel_valid/pixel_ready carries one RGB pixel per item;
// output channel hsl/hsl_valid/hsl_ready carries hue, saturation and
// lightness as 16-bit fractions. Both use valid/ready, an item moves on a
// clock edge where both are high.
// Throughput: one pixel per clock while the skid register is empty. Stages:
// three for max/min, differences and hue numerator, then 18 stages in each
// of the two parallel dividers for hue and saturation (one setup stage plus
// one quotient bit per stage for 17 bits), with lightness taken from a
// reciprocal multiply and carried alongside them, then the output register.
// Reset (rst, synchronous) empties the pipeline and the output side.
// When the receiver stalls, a held result sits in the output register and
// the next one lands in a one-entry skid register; while the skid is full,
// pixel_ready is low and every stage holds, so nothing is lost or repeated.
// Gray pixels give zero hue and saturation.
module rgb_to_hsl
  import rgbhsl_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   pixel_valid,
  output logic   pixel_ready,
  input  pixel_t pixel,
  output logic   hsl_valid,
  input  logic   hsl_ready,
  output hsl_t   hsl
);

  localparam int CB = CHANNEL_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int QW = FB + 1;
  localparam int HW = CB + 3;
  localparam int SW = CB + 1;

  localparam logic [SW-1:0] TWO_M = SW'(2 * CHAN_MAX);
  localparam logic [SW-1:0] M_SUM = SW'(CHAN_MAX);

  // lightness = floor((sum * 2^(FB-1) + (M-1)/2) / M), M = 2^CB - 1
  localparam int LIT_SH = FB - 1 - CB;
  localparam int LIT_K  = FB + CB;
  localparam int LPW    = 2 * QW;
  localparam logic [FB:0] LIT_HALF  = QW'((CHAN_MAX - 1) / 2);
  localparam logic [FB:0] LIT_RECIP =
    QW'(((longint'(1) << LIT_K) + longint'(CHAN_MAX) - 1) / longint'(CHAN_MAX));

  typedef enum logic [1:0] {SEL_RED, SEL_GREEN, SEL_BLUE} max_sel_t;

  logic en;
  logic skid_valid;
  hsl_t skid;

  // stage 1: input register
  logic   s1_valid;
  pixel_t s1_pix;

  // stage 2: range and sum
  logic          s2_valid;
  logic [CB-1:0] s2_d;
  logic [SW-1:0] s2_sum;
  max_sel_t      s2_sel;
  pixel_t        s2_pix;

  // stage 3: divider operands
  logic          s3_valid;
  logic          s3_gray;
  logic [HW-1:0] s3_hue_n;
  logic [HW-1:0] s3_six_d;
  logic [SW-1:0] s3_sum;
  logic [CB-1:0] s3_d;
  logic [SW-1:0] s3_sat_den;

  // valid and gray flags alongside the dividers
  logic dv [0:QW];
  logic dg [0:QW];

  // lightness path alongside the dividers
  logic [FB:0]    lit_base3;
  logic [FB:0]    lit_z3;
  logic [LPW-1:0] lit_prod;
  logic [FB:0]    lit_base;
  logic [FB:0]    lit_d [1:QW];

  logic [FB:0] hue_q;
  logic [FB:0] sat_q;
  hsl_t        res;

  max_sel_t      sel1;
  logic [CB-1:0] mx1;
  logic [CB-1:0] mn1;

  logic [HW-1:0] six_d2;
  logic [HW-1:0] pos2;
  logic [HW-1:0] neg2;
  logic [HW-1:0] n2;
  logic [SW-1:0] sat_den2;

  // the whole pipeline holds while a result waits in the skid
  assign en          = !skid_valid;
  assign pixel_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pixel_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // largest channel, red wins ties over green, green over blue
  always_comb begin
    priority if (s1_pix.red >= s1_pix.green && s1_pix.red >= s1_pix.blue) begin
      sel1 = SEL_RED;
    end else if (s1_pix.green >= s1_pix.blue) begin
      sel1 = SEL_GREEN;
    end else begin
      sel1 = SEL_BLUE;
    end
    unique case (sel1)
      SEL_RED:   mx1 = s1_pix.red;
      SEL_GREEN: mx1 = s1_pix.green;
      SEL_BLUE:  mx1 = s1_pix.blue;
      default:   mx1 = s1_pix.blue;
    endcase
    priority if (s1_pix.red <= s1_pix.green && s1_pix.red <= s1_pix.blue) begin
      mn1 = s1_pix.red;
    end else if (s1_pix.green <= s1_pix.blue) begin
      mn1 = s1_pix.green;
    end else begin
      mn1 = s1_pix.blue;
    end
  end

  // hue numerator over 6d, brought into 0..6d
  always_comb begin
    six_d2 = HW'({s2_d, 2'b00}) + HW'({s2_d, 1'b0});
    unique case (s2_sel)
      SEL_RED: begin
        pos2 = HW'(s2_pix.green);
        neg2 = HW'(s2_pix.blue);
      end
      SEL_GREEN: begin
        pos2 = HW'({s2_d, 1'b0}) + HW'(s2_pix.blue);
        neg2 = HW'(s2_pix.red);
      end
      default: begin
        pos2 = HW'({s2_d, 2'b00}) + HW'(s2_pix.red);
        neg2 = HW'(s2_pix.green);
      end
    endcase
    n2       = (pos2 >= neg2) ? pos2 - neg2 : pos2 + six_d2 - neg2;
    sat_den2 = (s2_sum < M_SUM) ? s2_sum : TWO_M - s2_sum;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix     <= pixel;
      s2_d       <= mx1 - mn1;
      s2_sum     <= SW'(mx1) + SW'(mn1);
      s2_sel     <= sel1;
      s2_pix     <= s1_pix;
      s3_gray    <= (s2_d == '0);
      s3_hue_n   <= n2;
      s3_six_d   <= six_d2;
      s3_sum     <= s2_sum;
      s3_d       <= s2_d;
      s3_sat_den <= sat_den2;
    end
  end

  rgbhsl_div #(.W(HW), .FB(FB)) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (s3_hue_n),
    .den (s3_six_d),
    .quo (hue_q)
  );

  rgbhsl_div #(.W(SW), .FB(FB)) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (SW'(s3_d)),
    .den (s3_sat_den),
    .quo (sat_q)
  );

  // sum * 2^(FB-1) splits into a multiple of M plus a small remainder;
  // divide the remainder by M with a reciprocal multiply, exact below 2^FB
  assign lit_base3 = QW'(s3_sum) << LIT_SH;
  assign lit_z3    = lit_base3 + LIT_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      lit_prod  <= LPW'(lit_z3) * LPW'(LIT_RECIP);
      lit_base  <= lit_base3;
      lit_d[1]  <= lit_base + QW'(lit_prod >> LIT_K);
      for (int k = 1; k < QW; k++) begin
        lit_d[k+1] <= lit_d[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) begin
        dv[k] <= 1'b0;
      end
    end else if (en) begin
      dv[0] <= s3_valid;
      for (int k = 0; k < QW; k++) begin
        dv[k+1] <= dv[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dg[0] <= s3_gray;
      for (int k = 0; k < QW; k++) begin
        dg[k+1] <= dg[k];
      end
    end
  end

  // a quotient of exactly one turn wraps to zero; saturation and lightness clamp
  always_comb begin
    res.hue        = dg[QW] ? '0 : hue_q[FB-1:0];
    res.saturation = dg[QW] ? '0 : (sat_q[FB] ? '1 : sat_q[FB-1:0]);
    res.lightness  = lit_d[QW][FB] ? '1 : lit_d[QW][FB-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsl_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (!hsl_valid || hsl_ready) begin
          hsl_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (dv[QW]) begin
        if (!hsl_valid || hsl_ready) begin
          hsl_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (hsl_ready) begin
        hsl_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!hsl_valid || hsl_ready) begin
        hsl <= skid;
      end
    end else if (dv[QW]) begin
      if (!hsl_valid || hsl_ready) begin
        hsl <= res;
      end else begin
        skid <= res;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> hsl_valid)
    else $error("skid holds an item while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && hsl_ready) |=> (hsl_valid && !skid_valid))
    else $error("skid item not moved to output after a take");

  a_park_in_skid: assert property (@(posedge clk) disable iff (rst)
    (dv[QW] && !skid_valid && hsl_valid && !hsl_ready) |=> skid_valid)
    else $error("finished item dropped while output stalled");

endmodule

>>> hw/rtl/rgbhsl_div.sv
// Pipelined restoring divider: round(num * 2^FB / den), one quotient bit per stage.
module rgbhsl_div #(
  parameter int W  = 9,
  parameter int FB = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic [FB:0]  quo
);

  localparam int QW = FB + 1;
  localparam int NW = W + FB;

  logic [NW-1:0] n_full;

  logic [W-1:0]  rem   [0:QW-1];
  logic [QW-1:0] low   [0:QW-1];
  logic [W-1:0]  dvs   [0:QW-1];
  logic [QW-1:0] quo_r [1:QW];

  logic [W+1:0]  trial [0:QW-1];
  logic [W-1:0]  nrem  [0:QW-1];
  logic [QW-1:0] take;

  // add half the divisor up front so the truncating division rounds to nearest
  assign n_full = {num, {FB{1'b0}}} + NW'(den >> 1);

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k] = {1'b0, rem[k], low[k][QW-1]} - {2'b00, dvs[k]};
      take[k]  = !trial[k][W+1];
      nrem[k]  = take[k] ? trial[k][W-1:0] : {rem[k][W-2:0], low[k][QW-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= W'(n_full[NW-1:QW]);
      low[0] <= n_full[QW-1:0];
      dvs[0] <= den;
      for (int k = 0; k < QW - 1; k++) begin
        rem[k+1] <= nrem[k];
        low[k+1] <= low[k] << 1;
        dvs[k+1] <= dvs[k];
      end
      quo_r[1] <= QW'(take[0]);
      for (int k = 1; k < QW; k++) begin
        quo_r[k+1] <= {quo_r[k][QW-2:0], take[k]};
      end
    end
  end

  assign quo = quo_r[QW];

endmodule

>>> test/testbench.sv
// Testbench for rgb_to_hsl: random and directed pixels checked against a built-in HSL predictor.
module testbench
  import rgbhsl_pkg::*;
();

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_OFF     = 600;
  localparam int DRAIN_CYCLES = 40;

  class HslScoreboard;
    hsl_t expected_hsl[$];
    int   pixels_seen;
    int   results_checked;
    int   gray_seen;
    int   tie_seen;
    int   mismatches;

    // num * 2^FRACTION_BITS / den, rounded to nearest with ties up
    function logic [63:0] scaled_ratio(logic [63:0] num, logic [63:0] den);
      return ((num << FRACTION_BITS) + (den >> 1)) / den;
    endfunction

    function logic [63:0] clamp_one(logic [63:0] v);
      logic [63:0] top;
      top = (64'd1 << FRACTION_BITS) - 1;
      return (v > top) ? top : v;
    endfunction

    function hsl_t predict_hsl(pixel_t p);
      logic [63:0] r, g, b, hi, lo, span, total, up, down, turn, m;
      hsl_t res;
      m = 64'(CHAN_MAX);
      r = 64'(p.red);
      g = 64'(p.green);
      b = 64'(p.blue);
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      total = hi + lo;
      res = '0;
      res.lightness = FRACTION_BITS'(clamp_one(scaled_ratio(total, 2 * m)));
      if (span != 0) begin
        if (total < m) begin
          res.saturation = FRACTION_BITS'(clamp_one(scaled_ratio(span, total)));
        end else begin
          res.saturation = FRACTION_BITS'(clamp_one(scaled_ratio(span, 2 * m - total)));
        end
        // red wins ties for the largest channel, then green
        if (r == hi) begin
          up = g;
          down = b;
        end else if (g == hi) begin
          up = 2 * span + b;
          down = r;
        end else begin
          up = 4 * span + r;
          down = g;
        end
        turn = (up >= down) ? up - down : up + 6 * span - down;
        res.hue = FRACTION_BITS'(scaled_ratio(turn, 6 * span));
      end
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      pixels_seen++;
      if (p.red == p.green && p.green == p.blue) begin
        gray_seen++;
      end else if (p.red == p.green || p.green == p.blue || p.red == p.blue) begin
        tie_seen++;
      end
      expected_hsl.push_back(predict_hsl(p));
    endfunction

    function void check_hsl(hsl_t got);
      hsl_t want;
      if (expected_hsl.size() == 0) begin
        $error("hsl item arrived with no pixel pending: hue %0d sat %0d light %0d",
               got.hue, got.saturation, got.lightness);
        mismatches++;
        return;
      end
      want = expected_hsl.pop_front();
      results_checked++;
      if (got.hue !== want.hue) begin
        $error("hue mismatch: expected %0d, got %0d", want.hue, got.hue);
        mismatches++;
      end
      if (got.saturation !== want.saturation) begin
        $error("saturation mismatch: expected %0d, got %0d", want.saturation,
               got.saturation);
        mismatches++;
      end
      if (got.lightness !== want.lightness) begin
        $error("lightness mismatch: expected %0d, got %0d", want.lightness,
               got.lightness);
        mismatches++;
      end
    endfunction
  endclass

  logic   clk;
  logic   rst;
  logic   pixel_valid;
  logic   pixel_ready;
  pixel_t pixel;
  logic   hsl_valid;
  logic   hsl_ready;
  hsl_t   hsl;

  HslScoreboard hsl_board = new();
  int cycle_count = 0;
  int pixels_sent = 0;

  rgb_to_hsl dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_ready(pixel_ready),
    .pixel      (pixel),
    .hsl_valid  (hsl_valid),
    .hsl_ready  (hsl_ready),
    .hsl        (hsl)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rgb_to_hsl verification failed");
      $finish;
    end
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst && pixel_valid && pixel_ready) hsl_board.note_pixel(pixel);
    if (!rst && hsl_valid && hsl_ready) hsl_board.check_hsl(hsl);
  end

  // offer one pixel after a random gap, or none in back-to-back stretches, and hold it until taken
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = ((pixels_sent / 40) % 4 == 1) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (!pixel_ready);
    pixels_sent++;
  endtask

  function automatic logic [7:0] edge_channel();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    logic [7:0] a, c;
    a = 8'($urandom_range(0, 255));
    c = 8'($urandom_range(0, 255));
    p = 24'($urandom);
    case ($urandom_range(0, 9))
      0: p = {a, a, a};
      1: p = {a, a, c};
      2: p = ($urandom_range(0, 1) == 0) ? {c, a, a} : {a, c, a};
      3: p = {edge_channel(), edge_channel(), edge_channel()};
      default: ;
    endcase
    return p;
  endfunction

  // receiver: random stalls, zero-stall stretches, and one long hold-off
  initial begin
    int taken;
    int gap;
    taken = 0;
    @(negedge rst);
    forever begin
      gap = ((taken / 50) % 3 == 2) ? 0 : $urandom_range(0, 17);
      if (taken == 150) gap = HOLD_OFF;
      if (gap > 0) begin
        hsl_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      hsl_ready <= 1'b1;
      do @(posedge clk); while (!hsl_valid);
      taken++;
    end
  end

  initial begin
    rst <= 1'b1;
    pixel_valid <= 1'b0;
    pixel <= '0;
    hsl_ready <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_pixel({8'd0, 8'd0, 8'd0});
    send_pixel({8'd255, 8'd255, 8'd255});
    send_pixel({8'd128, 8'd128, 8'd128});
    send_pixel({8'd255, 8'd0, 8'd0});
    send_pixel({8'd0, 8'd255, 8'd0});
    send_pixel({8'd0, 8'd0, 8'd255});
    send_pixel({8'd255, 8'd255, 8'd0});   // red and green tie
    send_pixel({8'd0, 8'd255, 8'd255});   // green and blue tie
    send_pixel({8'd255, 8'd0, 8'd255});   // red and blue tie
    send_pixel({8'd255, 8'd0, 8'd1});     // hue just short of a full turn
    send_pixel({8'd200, 8'd10, 8'd11});
    send_pixel({8'd127, 8'd0, 8'd0});     // dark side, saturation at full scale
    send_pixel({8'd128, 8'd127, 8'd127}); // max + min right at half scale
    send_pixel({8'd127, 8'd128, 8'd127});
    send_pixel({8'd1, 8'd0, 8'd0});
    send_pixel({8'd254, 8'd255, 8'd255});
    send_pixel({8'd170, 8'd85, 8'd170});
    send_pixel({8'd85, 8'd170, 8'd85});
    send_pixel({8'd10, 8'd20, 8'd30});
    send_pixel({8'd30, 8'd20, 8'd10});

    repeat (RANDOM_ITEMS) send_pixel(random_pixel());

    pixel_valid <= 1'b0;
    while (hsl_board.expected_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d gray, %0d with two equal channels), %0d HSL items",
             hsl_board.pixels_seen, hsl_board.gray_seen, hsl_board.tie_seen,
             hsl_board.results_checked);
    $display("Ran with random stalls on both sides and one %0d-cycle output hold-off",
             HOLD_OFF);
    if (hsl_board.mismatches == 0) begin
      $display("rgb_to_hsl verification clean");
    end else begin
      $display("rgb_to_hsl verification failed");
    end
    $finish;
  end

endmodule
